@@ hdl/fifo_with_entry_timeout_top_assert.svh @@
// Assertion macros shared by the timeout FIFO RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef FIFO_WITH_ENTRY_TIMEOUT_TOP_ASSERT_SVH
`define FIFO_WITH_ENTRY_TIMEOUT_TOP_ASSERT_SVH

// Check an expression at every clock edge outside reset.
`define FWET_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define FWET_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

@@ hdl/fwet_pkg.sv @@
// Types and codes for the timeout FIFO.
// No dependencies; imported by fifo_with_entry_timeout_top.
package fwet_pkg;

  // Operation codes on the func field
  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_POP  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  // Status codes on the result
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] push_payload;
    logic [15:0] push_wait;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pop_payload;
    logic [15:0] pop_wait;
    logic [4:0]  entry_count;
    logic        is_empty;
  } rsp_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_DATA,
    S_TICK,
    S_FINISH
  } fwet_state_t;

endpackage

@@ hdl/fifo_with_entry_timeout_top.sv @@
// Bounded FIFO with a wait count per entry; tick expires and ages entries.
// Depends on fwet_pkg and fifo_with_entry_timeout_top_assert.svh.
//
//   channel | valid     | stall     | word
//   --------+-----------+-----------+----------------------------------
//   request | req_valid | req_stall | req  (func, payload, wait)
//   result  | rsp_valid | rsp_stall | rsp  (status, popped entry, count)
//
// Push and no-op go straight to finish; pop adds one registered memory read.
// Tick walks the stored entries through the single memory read port, one per
// cycle, compacting survivors in place.
// Reset clears state, occupancy, head, tail and valids; slot contents need no clearing.
// A held result does not block acceptance of the next word; the next
// result waits in the finish state until the output register frees.
module fifo_with_entry_timeout_top #(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_WIDTH = 16,
  parameter int WAIT_WIDTH    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  fwet_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output fwet_pkg::rsp_word_t rsp
);
  import fwet_pkg::*;

  `include "fifo_with_entry_timeout_top_assert.svh"

  localparam int AW     = $clog2(DEPTH);
  localparam int OW     = $clog2(DEPTH + 1);
  localparam int MW     = PAYLOAD_WIDTH + WAIT_WIDTH;
  localparam int PW_EXT = (PAYLOAD_WIDTH > 16) ? PAYLOAD_WIDTH : 16;
  localparam int WW_EXT = (WAIT_WIDTH > 16) ? WAIT_WIDTH : 16;
  localparam int OC_EXT = (OW > 5) ? OW : 5;

  fwet_state_t state, state_next;

  // Control registers
  logic [OW-1:0] occ;
  logic [AW-1:0] head, tail;
  logic [AW-1:0] rd_ptr, wr_ptr;
  logic [OW-1:0] issued, surv;
  logic          pend_vld;
  logic [1:0]    pend_status;
  logic [15:0]   pend_pp, pend_pw;

  // Slot memory
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rd_data;
  logic          rd_en, we;
  logic [AW-1:0] rd_addr, waddr;
  logic [MW-1:0] wdata;

  logic req_acc, out_free;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  logic [WAIT_WIDTH-1:0]    rd_wait;
  logic [PW_EXT-1:0]        push_pay_ext, rd_pay_ext;
  logic [WW_EXT-1:0]        push_wait_ext, rd_wait_ext;
  logic [OC_EXT-1:0]        occ_ext;
  logic                     tick_done, surv_hit;

  assign req_acc  = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign rd_pay   = rd_data[MW-1:WAIT_WIDTH];
  assign rd_wait  = rd_data[WAIT_WIDTH-1:0];

  assign push_pay_ext  = PW_EXT'(req.push_payload);
  assign push_wait_ext = WW_EXT'(req.push_wait);
  assign rd_pay_ext    = PW_EXT'(rd_pay);
  assign rd_wait_ext   = WW_EXT'(rd_wait);
  assign occ_ext       = OC_EXT'(occ);

  assign tick_done = (issued == occ) && !pend_vld;
  assign surv_hit  = pend_vld && (rd_wait != '0);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    return r;
  endfunction

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory port controls and stall
  always_comb begin
    state_next = state;
    req_stall  = (state != S_IDLE);
    rd_en      = 1'b0;
    rd_addr    = head;
    we         = 1'b0;
    waddr      = tail;
    wdata      = {push_pay_ext[PAYLOAD_WIDTH-1:0], push_wait_ext[WAIT_WIDTH-1:0]};
    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          state_next = S_FINISH;
          if (req.func == FUNC_PUSH && occ != OW'(DEPTH)) begin
            we = 1'b1;
          end else if (req.func == FUNC_POP && occ != '0) begin
            rd_en      = 1'b1;
            state_next = S_POP_DATA;
          end else if (req.func == FUNC_TICK && occ != '0) begin
            state_next = S_TICK;
          end
        end
      end
      S_POP_DATA: begin
        state_next = S_FINISH;
      end
      S_TICK: begin
        rd_en   = (issued != occ);
        rd_addr = rd_ptr;
        we      = surv_hit;
        waddr   = wr_ptr;
        wdata   = {rd_pay, rd_wait - WAIT_WIDTH'(1)};
        if (tick_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Write and read the slot memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Advance pointers, counts and the pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= '0;
      head     <= '0;
      tail     <= '0;
      pend_vld <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            pend_status <= ST_OK;
            pend_pp     <= '0;
            pend_pw     <= '0;
            rd_ptr      <= head;
            wr_ptr      <= head;
            issued      <= '0;
            surv        <= '0;
            pend_vld    <= 1'b0;
            if (req.func == FUNC_PUSH) begin
              if (occ == OW'(DEPTH)) begin
                pend_status <= ST_FULL;
              end else begin
                tail <= ptr_inc(tail);
                occ  <= occ + OW'(1);
              end
            end else if (req.func == FUNC_POP && occ == '0) begin
              pend_status <= ST_EMPTY;
            end
          end
        end
        S_POP_DATA: begin
          pend_pp <= rd_pay_ext[15:0];
          pend_pw <= rd_wait_ext[15:0];
          head    <= ptr_inc(head);
          occ     <= occ - OW'(1);
        end
        S_TICK: begin
          pend_vld <= rd_en;
          if (rd_en) begin
            rd_ptr <= ptr_inc(rd_ptr);
            issued <= issued + OW'(1);
          end
          if (surv_hit) begin
            wr_ptr <= ptr_inc(wr_ptr);
            surv   <= surv + OW'(1);
          end
          if (tick_done) begin
            occ  <= surv;
            tail <= wr_ptr;
          end
        end
        S_FINISH: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Load the result register; drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      rsp.status      <= pend_status;
      rsp.pop_payload <= pend_pp;
      rsp.pop_wait    <= pend_pw;
      rsp.entry_count <= occ_ext[4:0];
      rsp.is_empty    <= (occ == '0);
    end
  end

  `FWET_ASSERT(a_occ_bound, occ <= OW'(DEPTH), "occupancy above depth")
  `FWET_ASSERT(a_surv_le_issued, state != S_TICK || surv <= issued, "more survivors than reads")
  `FWET_ASSERT(a_issued_le_occ, state != S_TICK || issued <= occ, "tick read past occupancy")
  `FWET_ASSERT_NEXT(a_occ_idle_stable, state == S_IDLE && !req_acc, $stable(occ),
    "occupancy changed while idle")
endmodule
